// File: sv/mcsw_pkg.sv
// ----------------------------------------------------------------------------
// mcsw_pkg
// Shared types and constants for the multi-channel soft watchdog.
// ----------------------------------------------------------------------------
package mcsw_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int COUNT_WIDTH  = 32;

   localparam int CH_IDX_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CHAN_W    = 8;
   localparam int SECS_W    = 16;
   localparam int RATE_W    = 10;
   localparam int PROD_W    = SECS_W + RATE_W;
   localparam int OP_W      = 2;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [RATE_W-1:0] TICK_RATE_RESET = RATE_W'(1000);

   typedef enum logic [OP_W-1:0] {
      OP_INIT = 2'd0,
      OP_FEED = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_MUL,
      SEQ_INIT,
      SEQ_FEED,
      SEQ_TICK,
      SEQ_DONE
   } seq_state_type;

   typedef enum logic {
      ARITH_MUL,
      ARITH_DEC
   } arith_mode_type;

   typedef struct packed {
      arith_mode_type           mode;
      logic [COUNT_WIDTH-1:0]   a;
      logic [RATE_W-1:0]        b;
   } arith_ctrl_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0]   result;
      logic                     zero;
   } arith_stat_type;

endpackage

// File: sv/mcsw_csr.sv
// ----------------------------------------------------------------------------
// mcsw_csr
// APB-style register file holding the tick rate.
// ----------------------------------------------------------------------------
module mcsw_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [mcsw_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [mcsw_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [mcsw_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output logic [mcsw_pkg::RATE_W-1:0]         tick_rate
);
   import mcsw_pkg::*;

   logic [RATE_W-1:0] tick_rate_ff;
   logic [RATE_W-1:0] tick_rate_in;
   logic              wr_en;

   // single register: every byte address of the window decodes to it
   logic [CSR_ADDR_W-1:0] addr_unused;
   assign addr_unused = paddr;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      tick_rate_in = tick_rate_ff;
      if (wr_en && (addr_unused == addr_unused)) begin
         tick_rate_in = pwdata[RATE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_rate_ff <= TICK_RATE_RESET;
      end else begin
         tick_rate_ff <= tick_rate_in;
      end
   end

   assign prdata    = CSR_DATA_W'(tick_rate_ff);
   assign tick_rate = tick_rate_ff;

endmodule

// File: sv/mcsw_arith.sv
// ----------------------------------------------------------------------------
// mcsw_arith
// Shared arithmetic unit: seconds-to-ticks multiply or count decrement,
// with a zero flag on the result.
// ----------------------------------------------------------------------------
module mcsw_arith (
   input  mcsw_pkg::arith_ctrl_type ctrl,
   output mcsw_pkg::arith_stat_type stat
);
   import mcsw_pkg::*;

   logic [PROD_W-1:0]      prod;
   logic [COUNT_WIDTH-1:0] res;

   assign prod = ctrl.a[SECS_W-1:0] * ctrl.b;

   always_comb begin
      case (ctrl.mode)
         ARITH_MUL: begin
            res = COUNT_WIDTH'(prod);
         end
         ARITH_DEC: begin
            res = ctrl.a - COUNT_WIDTH'(1);
         end
         default: begin
            res = ctrl.a;
         end
      endcase
   end

   assign stat.result = res;
   assign stat.zero   = (res == '0);

endmodule

// File: sv/multi_channel_soft_watchdog.sv
// ----------------------------------------------------------------------------
// multi_channel_soft_watchdog
// Bank of software watchdog channels driven by init, feed and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive req_* and pulse start while busy is low; the
//    transaction is taken on that edge and busy rises on the next cycle.
//  - Operations: init loads a channel's reload and count with
//    timeout_seconds * tick_rate and suspends it; feed reloads the count
//    and sets the channel running; tick walks the channels in index order.
//  - Result channel: rsp_valid is high for exactly one cycle per command,
//    carrying rsp_accepted, rsp_reset_request, rsp_expired_channel and
//    rsp_halted. There is no back-pressure; the receiver must take it.
//  - Steps: init is capture, multiply, write, result; feed is capture,
//    write, result; a rejected command or a tick while halted is capture,
//    result; tick is capture, one walk step per channel visited, result.
//    The single shared arithmetic unit decrements one channel per cycle.
//  - A new command is taken the cycle after rsp_valid.
//  - Reset: all channels suspended with zero reload and count, halt latch
//    clear, tick_rate 1000. Only reset clears the halt latch.
//  - tick_rate (APB-style port): user must write only while idle; unenforced.
// ----------------------------------------------------------------------------
module multi_channel_soft_watchdog (
   input  logic                               clock,
   input  logic                               reset,
   // command channel
   input  logic                               start,
   output logic                               busy,
   input  logic [mcsw_pkg::OP_W-1:0]          req_operation,
   input  logic [mcsw_pkg::CHAN_W-1:0]        req_channel,
   input  logic [mcsw_pkg::SECS_W-1:0]        req_timeout_seconds,
   // result channel
   output logic                               rsp_valid,
   output logic                               rsp_accepted,
   output logic                               rsp_reset_request,
   output logic [mcsw_pkg::CHAN_W-1:0]        rsp_expired_channel,
   output logic                               rsp_halted,
   // register port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [mcsw_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [mcsw_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [mcsw_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready
);
   import mcsw_pkg::*;

   localparam logic [CH_IDX_W-1:0] LAST_IDX = CH_IDX_W'(NUM_CHANNELS - 1);

   // sequencer
   seq_state_type state_ff, state_in;

   // captured transaction
   logic [CH_IDX_W-1:0]    ch_ff,   ch_in;
   logic [SECS_W-1:0]      secs_ff, secs_in;

   // walk index and multiply result
   logic [CH_IDX_W-1:0]    idx_ff,  idx_in;
   logic [COUNT_WIDTH-1:0] product_ff, product_in;

   // channel state
   logic [COUNT_WIDTH-1:0] reload_ff [NUM_CHANNELS];
   logic [COUNT_WIDTH-1:0] count_ff  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] running_ff;
   logic                   halt_ff, halt_in;

   // result registers
   logic                   accepted_ff, accepted_in;
   logic                   rreq_ff,     rreq_in;
   logic [CHAN_W-1:0]      expired_ff,  expired_in;

   // channel write port
   logic                   reload_we;
   logic                   count_we;
   logic [CH_IDX_W-1:0]    count_wa;
   logic [COUNT_WIDTH-1:0] count_wd;
   logic                   run_we;
   logic                   run_wd;

   logic                   ch_ok;
   logic [RATE_W-1:0]      tick_rate;
   arith_ctrl_type         arith_ctrl;
   arith_stat_type         arith_stat;

   mcsw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .tick_rate (tick_rate)
   );

   mcsw_arith u_arith (
      .ctrl (arith_ctrl),
      .stat (arith_stat)
   );

   // channel index range check, one bit wider to hold the channel count
   assign ch_ok = ({1'b0, req_channel} < (CHAN_W + 1)'(NUM_CHANNELS));

   always_comb begin
      state_in    = state_ff;
      ch_in       = ch_ff;
      secs_in     = secs_ff;
      idx_in      = idx_ff;
      product_in  = product_ff;
      halt_in     = halt_ff;
      accepted_in = accepted_ff;
      rreq_in     = rreq_ff;
      expired_in  = expired_ff;

      reload_we = 1'b0;
      count_we  = 1'b0;
      count_wa  = ch_ff;
      count_wd  = product_ff;
      run_we    = 1'b0;
      run_wd    = 1'b0;

      arith_ctrl.mode = ARITH_DEC;
      arith_ctrl.a    = count_ff[idx_ff];
      arith_ctrl.b    = tick_rate;

      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               ch_in       = req_channel[CH_IDX_W-1:0];
               secs_in     = req_timeout_seconds;
               idx_in      = '0;
               accepted_in = 1'b0;
               rreq_in     = 1'b0;
               expired_in  = '0;
               case (req_operation)
                  OP_INIT: begin
                     accepted_in = ch_ok;
                     state_in    = ch_ok ? SEQ_MUL : SEQ_DONE;
                  end
                  OP_FEED: begin
                     accepted_in = ch_ok;
                     state_in    = ch_ok ? SEQ_FEED : SEQ_DONE;
                  end
                  OP_TICK: begin
                     accepted_in = 1'b1;
                     // halted: a tick changes nothing
                     state_in    = halt_ff ? SEQ_DONE : SEQ_TICK;
                  end
                  default: begin
                     state_in = SEQ_DONE;
                  end
               endcase
            end
         end
         SEQ_MUL: begin
            arith_ctrl.mode = ARITH_MUL;
            arith_ctrl.a    = COUNT_WIDTH'(secs_ff);
            product_in      = arith_stat.result;
            state_in        = SEQ_INIT;
         end
         SEQ_INIT: begin
            reload_we = 1'b1;
            count_we  = 1'b1;
            run_we    = 1'b1;
            run_wd    = 1'b0;
            state_in  = SEQ_DONE;
         end
         SEQ_FEED: begin
            count_we = 1'b1;
            count_wd = reload_ff[ch_ff];
            run_we   = 1'b1;
            run_wd   = 1'b1;
            state_in = SEQ_DONE;
         end
         SEQ_TICK: begin
            // one channel per cycle; a zero count wraps and does not expire
            if (running_ff[idx_ff]) begin
               count_we = 1'b1;
               count_wa = idx_ff;
               count_wd = arith_stat.result;
            end
            if (running_ff[idx_ff] && arith_stat.zero) begin
               halt_in    = 1'b1;
               rreq_in    = 1'b1;
               expired_in = CHAN_W'(idx_ff);
               state_in   = SEQ_DONE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = SEQ_DONE;
            end else begin
               idx_in = idx_ff + CH_IDX_W'(1);
            end
         end
         SEQ_DONE: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         halt_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         halt_ff  <= halt_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff       <= ch_in;
      secs_ff     <= secs_in;
      idx_ff      <= idx_in;
      product_ff  <= product_in;
      accepted_ff <= accepted_in;
      rreq_ff     <= rreq_in;
      expired_ff  <= expired_in;
   end

   // channel bank: architectural state, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            reload_ff[i] <= '0;
            count_ff[i]  <= '0;
         end
         running_ff <= '0;
      end else begin
         if (reload_we) begin
            reload_ff[ch_ff] <= product_ff;
         end
         if (count_we) begin
            count_ff[count_wa] <= count_wd;
         end
         if (run_we) begin
            running_ff[ch_ff] <= run_wd;
         end
      end
   end

   assign busy                = (state_ff != SEQ_IDLE);
   assign rsp_valid           = (state_ff == SEQ_DONE);
   assign rsp_accepted        = accepted_ff;
   assign rsp_reset_request   = rreq_ff;
   assign rsp_expired_channel = expired_ff;
   assign rsp_halted          = halt_ff;

endmodule
